>>> hw/rtl/json_su_pkg.sv
`timescale 1ns / 1ps
package json_su_pkg;

    localparam int LEN_W = 24;
    localparam logic [LEN_W-1:0] DLEN_MAX = 24'hFFFFFF;
    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [2:0] ERR_ESCAPE     = 3'd2;
    localparam logic [2:0] ERR_HEX        = 3'd3;
    localparam logic [2:0] ERR_EOI        = 3'd4;

    // work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_ERROR = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       out_byte;
        logic             run_last;
        logic [2:0]       error_code;
        logic [LEN_W-1:0] decoded_length;
    } t_out;

    typedef struct packed {
        t_op        op;
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [2:0] err;
    } t_job;

    // {ok, value} of an ASCII hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {ok, byte} for the single-letter escapes
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h22, 8'h2F, 8'h5C: r = {1'b1, c};
            8'h62: r = {1'b1, 8'h08};
            8'h66: r = {1'b1, 8'h0C};
            8'h6E: r = {1'b1, 8'h0A};
            8'h72: r = {1'b1, 8'h0D};
            8'h74: r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/json_su_front.sv
`timescale 1ns / 1ps
module json_su_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  json_su_pkg::t_in  i_data,
    output logic              o_push,
    output json_su_pkg::t_job o_job
);

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_digits, n_digits;
    logic [15:0] r_code, n_code;

    logic [7:0]  c;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [15:0] u;
    logic        is_ws;

    assign c     = i_data.data_byte;
    assign hex   = json_su_pkg::hex_value(c);
    assign esc   = json_su_pkg::escape_map(c);
    assign u     = {r_code[11:0], hex[3:0]};
    assign is_ws = (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
                   (c == 8'h0B) || (c == 8'h0C);

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_code   = r_code;
        o_push   = 1'b0;
        o_job    = '0;
        o_job.op = json_su_pkg::OP_BYTE;
        if (i_accept) begin
            if (i_data.end_of_input) begin
                if (r_mode != MODE_IDLE) begin
                    o_push    = 1'b1;
                    o_job.op  = json_su_pkg::OP_ERROR;
                    o_job.err = json_su_pkg::ERR_EOI;
                    n_mode    = MODE_IDLE;
                    n_digits  = 2'd0;
                    n_code    = 16'd0;
                end
            end else begin
                case (r_mode)
                    MODE_IDLE: begin
                        if (c == 8'h22) begin
                            o_push   = 1'b1;
                            o_job.op = json_su_pkg::OP_OPEN;
                            n_mode   = MODE_STR;
                        end else if (!is_ws) begin
                            o_push    = 1'b1;
                            o_job.op  = json_su_pkg::OP_ERROR;
                            o_job.err = json_su_pkg::ERR_UNEXPECTED;
                        end
                    end
                    MODE_STR: begin
                        if (c == 8'h22) begin
                            o_push   = 1'b1;
                            o_job.op = json_su_pkg::OP_CLOSE;
                            n_mode   = MODE_IDLE;
                        end else if (c == 8'h5C) begin
                            n_mode = MODE_ESC;
                        end else begin
                            o_push       = 1'b1;
                            o_job.nbytes = 2'd1;
                            o_job.b0     = c;
                        end
                    end
                    MODE_ESC: begin
                        if (c == 8'h75) begin
                            n_mode   = MODE_HEX;
                            n_digits = 2'd0;
                            n_code   = 16'd0;
                        end else if (esc[8]) begin
                            o_push       = 1'b1;
                            o_job.nbytes = 2'd1;
                            o_job.b0     = esc[7:0];
                            n_mode       = MODE_STR;
                        end else begin
                            o_push    = 1'b1;
                            o_job.op  = json_su_pkg::OP_ERROR;
                            o_job.err = json_su_pkg::ERR_ESCAPE;
                            n_mode    = MODE_IDLE;
                            n_digits  = 2'd0;
                            n_code    = 16'd0;
                        end
                    end
                    MODE_HEX: begin
                        if (!hex[4]) begin
                            o_push    = 1'b1;
                            o_job.op  = json_su_pkg::OP_ERROR;
                            o_job.err = json_su_pkg::ERR_HEX;
                            n_mode    = MODE_IDLE;
                            n_digits  = 2'd0;
                            n_code    = 16'd0;
                        end else if (r_digits != 2'd3) begin
                            n_digits = r_digits + 2'd1;
                            n_code   = u;
                        end else begin
                            // last digit: encode the code unit as UTF-8
                            o_push   = 1'b1;
                            n_mode   = MODE_STR;
                            n_digits = 2'd0;
                            n_code   = 16'd0;
                            if (u < 16'h0080) begin
                                o_job.nbytes = 2'd1;
                                o_job.b0     = u[7:0];
                            end else if (u < 16'h0800) begin
                                o_job.nbytes = 2'd2;
                                o_job.b0     = {3'b110, u[10:6]};
                                o_job.b1     = {2'b10, u[5:0]};
                            end else begin
                                o_job.nbytes = 2'd3;
                                o_job.b0     = {4'b1110, u[15:12]};
                                o_job.b1     = {2'b10, u[11:6]};
                                o_job.b2     = {2'b10, u[5:0]};
                            end
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_digits <= 2'd0;
            r_code   <= 16'd0;
        end else begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_code   <= n_code;
        end
    end

    a_digits_in_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_digits != 2'd0) |-> (r_mode == MODE_HEX))
        else $error("hex digit count set outside a \\u escape");

endmodule

>>> hw/rtl/json_su_queue.sv
`timescale 1ns / 1ps
module json_su_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  json_su_pkg::t_job i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output json_su_pkg::t_job o_head
);

    localparam int DEPTH = json_su_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    json_su_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("word popped from an empty queue");

endmodule

>>> hw/rtl/json_su_back.sv
`timescale 1ns / 1ps
module json_su_back #(
    parameter int LENGTH_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  json_su_pkg::t_job i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output json_su_pkg::t_out o_data
);

    localparam int LW   = json_su_pkg::LEN_W;
    localparam int WIDE = (LENGTH_BITS > LW) ? LENGTH_BITS : LW;

    logic [LENGTH_BITS-1:0] r_cnt, n_cnt, cnt_inc;
    logic [1:0]             r_idx, n_idx;
    logic                   r_ov, n_ov;
    json_su_pkg::t_out      r_out, n_out;

    logic                   out_free;
    logic                   last_byte;
    logic [7:0]             sel_byte;

    function automatic logic [LW-1:0] shown(input logic [LENGTH_BITS-1:0] v);
        logic [WIDE-1:0] w;
        w = WIDE'(v);
        return (w > WIDE'(json_su_pkg::DLEN_MAX)) ? json_su_pkg::DLEN_MAX : w[LW-1:0];
    endfunction

    assign out_free  = !r_ov || !i_stall;
    assign cnt_inc   = (r_cnt == '1) ? r_cnt : r_cnt + LENGTH_BITS'(1);
    assign last_byte = ((r_idx + 2'd1) == i_head.nbytes);

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            2'd2:    sel_byte = i_head.b2;
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_ov  = out_free ? 1'b0 : r_ov;
        n_out = r_out;
        o_pop = 1'b0;
        if (!i_empty) begin
            case (i_head.op)
                json_su_pkg::OP_OPEN: begin
                    // a new string restarts the length
                    n_cnt = '0;
                    o_pop = 1'b1;
                end
                json_su_pkg::OP_BYTE: begin
                    if (out_free) begin
                        n_cnt                = cnt_inc;
                        n_ov                 = 1'b1;
                        n_out.kind           = json_su_pkg::KIND_BYTE;
                        n_out.out_byte       = sel_byte;
                        n_out.run_last       = last_byte;
                        n_out.error_code     = json_su_pkg::ERR_NONE;
                        n_out.decoded_length = shown(cnt_inc);
                        if (last_byte) begin
                            n_idx = 2'd0;
                            o_pop = 1'b1;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                end
                json_su_pkg::OP_CLOSE: begin
                    if (out_free) begin
                        n_ov                 = 1'b1;
                        n_out.kind           = json_su_pkg::KIND_CLOSE;
                        n_out.out_byte       = 8'd0;
                        n_out.run_last       = 1'b1;
                        n_out.error_code     = json_su_pkg::ERR_NONE;
                        n_out.decoded_length = shown(r_cnt);
                        o_pop                = 1'b1;
                    end
                end
                default: begin
                    if (out_free) begin
                        n_ov                 = 1'b1;
                        n_out.kind           = json_su_pkg::KIND_ERROR;
                        n_out.out_byte       = 8'd0;
                        n_out.run_last       = 1'b1;
                        n_out.error_code     = i_head.err;
                        n_out.decoded_length = '0;
                        o_pop                = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_closing_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind != json_su_pkg::KIND_BYTE) |-> o_data.run_last)
        else $error("close or error word not marked last");

    a_error_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == json_su_pkg::KIND_ERROR) |->
        (o_data.decoded_length == '0 && o_data.error_code != json_su_pkg::ERR_NONE))
        else $error("error word carries a length or no code");

endmodule

>>> hw/rtl/json_string_unescape.sv
`timescale 1ns / 1ps
// JSON string unescaper. Takes one byte of JSON text per cycle while the queue
// is not full and gives one result word per cycle while the output is not
// stalled: decoded content bytes, a close word with the decoded length, or an
// error word. A front end tracks the scan mode and turns each byte into a job
// of zero to three results; a four-entry queue carries the jobs to a back end
// that owns the length counter and an output register. A \uXXXX escape gives
// the back end one, two or three UTF-8 bytes to send while the front end keeps
// taking input until the queue fills. The input stalls only when the queue is
// full.
module json_string_unescape #(
    parameter int LENGTH_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  json_su_pkg::t_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output json_su_pkg::t_out o_data
);

    logic              q_full, q_empty, push, pop;
    json_su_pkg::t_job job, head;

    assign o_stall = q_full;

    json_su_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_valid && !q_full),
        .i_data   (i_data),
        .o_push   (push),
        .o_job    (job)
    );

    json_su_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    json_su_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
